// File: src/pacc_pkg.sv
package pacc_pkg;

  // Fixed port widths
  localparam int CoordPortW = 16;
  localparam int FuncW      = 3;
  localparam int KindW      = 2;
  localparam int AreaW      = 39;
  localparam int CountW     = 7;

  // Default sizing
  localparam int MaxVerticesDef = 64;
  localparam int CoordBitsDef   = 16;

  // Twice-area ceiling
  localparam logic [AreaW-1:0] AREA_LIMIT = AreaW'(64'd274877906944);

  // Request codes
  localparam logic [FuncW-1:0] FN_APPEND = 3'd0;
  localparam logic [FuncW-1:0] FN_CLEAR  = 3'd1;
  localparam logic [FuncW-1:0] FN_AREA   = 3'd2;
  localparam logic [FuncW-1:0] FN_CONVEX = 3'd3;
  localparam logic [FuncW-1:0] FN_INSIDE = 3'd4;

  // Result kinds
  localparam logic [KindW-1:0] KIND_AREA   = 2'd0;
  localparam logic [KindW-1:0] KIND_CONVEX = 2'd1;
  localparam logic [KindW-1:0] KIND_INSIDE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH1,
    ST_FLUSH2,
    ST_FIN
  } state_t;

  // Per-cycle control from the sequencer to the evaluator
  typedef struct packed {
    logic             start;
    logic             step_vld;
    logic [KindW-1:0] kind;
  } step_ctl_t;

endpackage

// File: src/pacc_cell.sv
module pacc_cell import pacc_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int IDX_W      = 6,
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_idx,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  logic                         shift_en,
  input  logic signed [COORD_BITS-1:0] nb_x,
  input  logic signed [COORD_BITS-1:0] nb_y,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y
);

  logic signed [COORD_BITS-1:0] x_r, y_r;

  // Rotate toward the head during a walk, load on append at own slot
  always_ff @(posedge clk) begin
    if (shift_en) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end else if (wr_en && (wr_idx == IDX_W'(IDX))) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

// File: src/pacc_eval.sv
module pacc_eval import pacc_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int ACC_W      = 42
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  step_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output logic signed [ACC_W-1:0]      acc,
  output logic                         turn_pos,
  output logic                         turn_neg,
  output logic                         parity
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] m1a, m1b, m2a, m2b;
  logic signed [PW-1:0] p1_r, p2_r;
  logic                 vld_r, straddle_r, dpos_r;
  logic [KindW-1:0]     kind_r;
  logic signed [PW:0]   t;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                 pos_r, neg_r, par_r, crossing;

  // Operand select per query kind
  always_comb begin
    case (ctl.kind)
      KIND_AREA: begin
        m1a = DW'(ax);  m1b = DW'(by);
        m2a = DW'(bx);  m2b = DW'(ay);
      end
      KIND_CONVEX: begin
        m1a = DW'(bx) - DW'(ax);  m1b = DW'(cy) - DW'(ay);
        m2a = DW'(by) - DW'(ay);  m2b = DW'(cx) - DW'(ax);
      end
      default: begin
        m1a = DW'(px) - DW'(ax);  m1b = DW'(by) - DW'(ay);
        m2a = DW'(bx) - DW'(ax);  m2b = DW'(py) - DW'(ay);
      end
    endcase
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    p1_r       <= m1a * m1b;
    p2_r       <= m2a * m2b;
    straddle_r <= (ay > py) != (by > py);
    dpos_r     <= by > ay;
    kind_r     <= ctl.kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.step_vld;
    end
  end

  // Stage 2: combine
  assign t        = (PW + 1)'(p1_r) - (PW + 1)'(p2_r);
  assign crossing = straddle_r && (dpos_r ? (p1_r < p2_r) : (p1_r > p2_r));
  assign acc_nxt  = acc_r + ACC_W'(t);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      acc_r <= '0;
      pos_r <= 1'b0;
      neg_r <= 1'b0;
      par_r <= 1'b0;
    end else if (vld_r) begin
      if (kind_r == KIND_AREA) acc_r <= acc_nxt;
      if (t > 0) pos_r <= 1'b1;
      if (t < 0) neg_r <= 1'b1;
      if (kind_r == KIND_INSIDE && crossing) par_r <= ~par_r;
    end
  end

  assign acc      = acc_r;
  assign turn_pos = pos_r;
  assign turn_neg = neg_r;
  assign parity   = par_r;

endmodule

// File: src/polygon_area_convexity_containment_core.sv
// Polygon vertex table with area, convexity and containment queries.
// Append and clear update the table as they are accepted; a query walks one
// full rotation of the vertex cell chain, then drains a two-stage evaluator.
// Items are handled one at a time; the next waits until the result is loaded.
// Reset (rst_n low, synchronous) empties the table and clears the lost flag;
// vertex storage itself is not cleared.
module polygon_area_convexity_containment_core import pacc_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int COORD_BITS   = CoordBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FuncW-1:0]      in_func,
  input  logic [CoordPortW-1:0] in_coord_x,
  input  logic [CoordPortW-1:0] in_coord_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KindW-1:0]      out_query_kind,
  output logic [AreaW-1:0]      out_double_area,
  output logic                  out_is_convex,
  output logic                  out_is_inside,
  output logic [CountW-1:0]     out_count_held,
  output logic                  out_lost_vertex
);

  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int ACC_W = 2 * (COORD_BITS + 1) + 1 + IW + 1;
  localparam int CMP_W = (ACC_W > AreaW) ? ACC_W : AreaW;

  state_t state_r, state_nxt;
  logic [CW-1:0]    count_r;
  logic             lost_r;
  logic [IW-1:0]    step_r;
  logic [KindW-1:0] kind_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, v0x_r, v0y_r, v1x_r, v1y_r;
  logic             accept, step_last, shift_en, wr_en, load_out;
  logic [CW:0]      s0, s1, s2, n_ext;
  logic signed [COORD_BITS-1:0] cx_arr [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cy_arr [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] bx, by, cx, cy;
  step_ctl_t        ctl;
  logic signed [ACC_W-1:0] acc;
  logic             turn_pos, turn_neg, parity;
  logic [CMP_W-1:0] area_abs;
  logic             out_valid_r;
  logic [KindW-1:0] o_kind_r;
  logic [AreaW-1:0] o_area_r;
  logic             o_convex_r, o_inside_r, o_lost_r;
  logic [CountW-1:0] o_count_r;

  assign accept    = in_valid && in_ready;
  assign wr_en     = accept && (in_func == FN_APPEND) && (count_r < CW'(MAX_VERTICES));
  assign step_last = step_r == IW'(MAX_VERTICES - 1);
  assign shift_en  = state_r == ST_RUN;

  // Vertex cell chain, rotating toward cell 0
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    localparam int NB = (k + 1) % MAX_VERTICES;
    pacc_cell #(.COORD_BITS(COORD_BITS), .IDX_W(IW), .IDX(k)) u_cell (
      .clk      (clk),
      .wr_en    (wr_en),
      .wr_idx   (count_r[IW-1:0]),
      .wr_x     (in_coord_x[COORD_BITS-1:0]),
      .wr_y     (in_coord_y[COORD_BITS-1:0]),
      .shift_en (shift_en),
      .nb_x     (cx_arr[NB]),
      .nb_y     (cy_arr[NB]),
      .x        (cx_arr[k]),
      .y        (cy_arr[k])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FN_AREA || in_func == FN_CONVEX ||
                       in_func == FN_INSIDE)) state_nxt = ST_RUN;
      end
      ST_RUN:    if (step_last) state_nxt = ST_FLUSH1;
      ST_FLUSH1: state_nxt = ST_FLUSH2;
      ST_FLUSH2: state_nxt = ST_FIN;
      ST_FIN:    if (!out_valid_r) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_FIN:  load_out = !out_valid_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      lost_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_func == FN_APPEND) begin
        if (wr_en) count_r <= count_r + CW'(1);
        else       lost_r  <= 1'b1;
      end
      if (accept && in_func == FN_CLEAR) count_r <= '0;
      if (shift_en) step_r <= step_last ? '0 : step_r + IW'(1);
    end
  end

  // Query point, kind and wrap vertices
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_coord_x[COORD_BITS-1:0];
      py_r <= in_coord_y[COORD_BITS-1:0];
      case (in_func)
        FN_AREA:   kind_r <= KIND_AREA;
        FN_CONVEX: kind_r <= KIND_CONVEX;
        default:   kind_r <= KIND_INSIDE;
      endcase
    end
    if (shift_en && step_r == '0) begin
      v0x_r <= cx_arr[0];
      v0y_r <= cy_arr[0];
      v1x_r <= cx_arr[1 % MAX_VERTICES];
      v1y_r <= cy_arr[1 % MAX_VERTICES];
    end
  end

  // Neighbor selection with wrap at the fill count
  assign s0    = (CW + 1)'(step_r);
  assign s1    = s0 + (CW + 1)'(1);
  assign s2    = s0 + (CW + 1)'(2);
  assign n_ext = (CW + 1)'(count_r);

  always_comb begin
    bx = cx_arr[1 % MAX_VERTICES];
    by = cy_arr[1 % MAX_VERTICES];
    cx = cx_arr[2 % MAX_VERTICES];
    cy = cy_arr[2 % MAX_VERTICES];
    if (s1 == n_ext) begin
      bx = (step_r == '0) ? cx_arr[0] : v0x_r;
      by = (step_r == '0) ? cy_arr[0] : v0y_r;
      cx = v1x_r;
      cy = v1y_r;
    end else if (s2 == n_ext) begin
      cx = (step_r == '0) ? cx_arr[0] : v0x_r;
      cy = (step_r == '0) ? cy_arr[0] : v0y_r;
    end
  end

  assign ctl.start    = accept;
  assign ctl.step_vld = shift_en && (s0 < n_ext);
  assign ctl.kind     = kind_r;

  pacc_eval #(.COORD_BITS(COORD_BITS), .ACC_W(ACC_W)) u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .ax       (cx_arr[0]),
    .ay       (cy_arr[0]),
    .bx       (bx),
    .by       (by),
    .cx       (cx),
    .cy       (cy),
    .px       (px_r),
    .py       (py_r),
    .acc      (acc),
    .turn_pos (turn_pos),
    .turn_neg (turn_neg),
    .parity   (parity)
  );

  assign area_abs = acc[ACC_W-1] ? CMP_W'(-acc) : CMP_W'(acc);

  // Result register; released on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_kind_r   <= kind_r;
      o_area_r   <= '0;
      o_convex_r <= 1'b0;
      o_inside_r <= 1'b0;
      case (kind_r)
        KIND_AREA:   o_area_r <= (area_abs > CMP_W'(AREA_LIMIT)) ? AREA_LIMIT
                                                                  : AreaW'(area_abs);
        KIND_CONVEX: o_convex_r <= (count_r >= CW'(3)) && !(turn_pos && turn_neg);
        default:     o_inside_r <= parity;
      endcase
      o_count_r <= CountW'(count_r);
      o_lost_r  <= lost_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_query_kind  = o_kind_r;
  assign out_double_area = o_area_r;
  assign out_is_convex   = o_convex_r;
  assign out_is_inside   = o_inside_r;
  assign out_count_held  = o_count_r;
  assign out_lost_vertex = o_lost_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTICES)) else $error("vertex count beyond table");

  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && step_last) |=> state_r == ST_FLUSH1)
    else $error("walk did not end after full rotation");

  a_step_home: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> step_r == '0) else $error("chain not back home");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r) else $error("result overwritten");

endmodule
